/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL modules of the pixel block writer.
// Depends on nothing; included by every file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_PROP(label, clk, rst_n, !(cond), msg)
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/core/spbw_pkg.sv */
// Package of the scaled pixel block writer: geometry constants, derived widths,
// register codes and the structs passed between front, queue and back.
`default_nettype none

package spbw_pkg;

	localparam int SRC_WIDTH  = 240;
	localparam int SRC_HEIGHT = 160;
	localparam int DST_WIDTH  = 1024;
	localparam int DST_HEIGHT = 768;
	localparam int MAX_WRITES = 16;

	// Integer scale factors and writes per block. A source pixel never
	// reaches past the destination edge, so every block has the full size.
	localparam int SCALE_X      = DST_WIDTH / SRC_WIDTH;
	localparam int SCALE_Y      = DST_HEIGHT / SRC_HEIGHT;
	localparam int BLOCK_AREA   = SCALE_X * SCALE_Y;
	localparam int BLOCK_WRITES = (BLOCK_AREA < MAX_WRITES) ? BLOCK_AREA : MAX_WRITES;
	localparam int LAST_N       = (BLOCK_WRITES > 0) ? BLOCK_WRITES - 1 : 0;
	localparam int LAST_COL     = (SCALE_X > 0) ? SCALE_X - 1 : 0;

	localparam int COL_W  = $clog2(DST_WIDTH + 1);
	localparam int ROW_W  = $clog2(DST_HEIGHT + 1);
	localparam int CCNT_W = $clog2(SCALE_X + 1);
	localparam int NCNT_W = $clog2(MAX_WRITES + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_BASE = 2'd0,
		REG_LINE_PITCH = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] frame_base;
		logic [15:0] line_pitch;
	} cfg_t;

	// One queued block: byte offset of its first write and expanded color.
	typedef struct packed {
		logic [31:0] offset;
		logic [23:0] color;
	} block_t;

endpackage

`default_nettype wire

/* rtl/core/spbw_in_if.sv */
// Pixel channel: valid/ready handshake with one source pixel as payload.
// Depends on nothing.
`default_nettype none

interface spbw_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  src_x;
	logic [7:0]  src_y;
	logic [15:0] src_color;

	modport source (output valid, output src_x, output src_y, output src_color, input ready);
	modport sink (input valid, input src_x, input src_y, input src_color, output ready);
endinterface

`default_nettype wire

/* rtl/core/spbw_out_if.sv */
// Write channel: valid/ready handshake with one framebuffer write as payload.
// Depends on nothing.
`default_nettype none

interface spbw_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] write_address;
	logic [23:0] write_data;
	logic        last_write;

	modport source (output valid, output write_address, output write_data,
		output last_write, input ready);
	modport sink (input valid, input write_address, input write_data,
		input last_write, output ready);
endinterface

`default_nettype wire

/* rtl/core/spbw_front.sv */
// Front of the pixel block writer: accepts pixels, drops those outside the
// source, expands the color and computes the block's byte offset. Uses spbw_pkg.
`default_nettype none

module spbw_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	spbw_in_if.sink             pixels,
	input  wire spbw_pkg::cfg_t cfg,
	output logic                push_valid,
	input  wire logic           push_ready,
	output spbw_pkg::block_t    push_block
);

	function automatic logic [7:0] widen5(input logic [4:0] c);
		widen5 = {c, c[4:2]};
	endfunction

	logic                       valid_s1;
	logic [spbw_pkg::ROW_W-1:0] row0_s1;
	logic [spbw_pkg::COL_W-1:0] col0_s1;
	logic [23:0]                color_s1;
	logic                       valid_s2;
	spbw_pkg::block_t           block_s2;
	logic                       s1_adv;
	logic                       in_range;

	assign s1_adv       = !valid_s2 || push_ready;
	assign pixels.ready = !valid_s1 || s1_adv;
	assign in_range     = (32'(pixels.src_x) < spbw_pkg::SRC_WIDTH) &&
		(32'(pixels.src_y) < spbw_pkg::SRC_HEIGHT) && (spbw_pkg::BLOCK_WRITES > 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pixels.ready) begin
				valid_s1 <= pixels.valid && in_range;
			end
			if (s1_adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pixels.ready) begin
			row0_s1  <= spbw_pkg::ROW_W'(32'(pixels.src_y) * spbw_pkg::SCALE_Y);
			col0_s1  <= spbw_pkg::COL_W'(32'(pixels.src_x) * spbw_pkg::SCALE_X);
			color_s1 <= {widen5(pixels.src_color[4:0]), widen5(pixels.src_color[9:5]),
				widen5(pixels.src_color[14:10])};
		end
		if (s1_adv) begin
			block_s2.offset <= 32'(32'(cfg.line_pitch) * 32'(row0_s1)) +
				32'({col0_s1, 2'b00});
			block_s2.color  <= color_s1;
		end
	end

	assign push_valid = valid_s2;
	assign push_block = block_s2;

endmodule

`default_nettype wire

/* rtl/core/spbw_queue.sv */
// Short block queue between front and back of the pixel block writer.
// Flop storage; depth from spbw_pkg.
`default_nettype none

module spbw_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire spbw_pkg::block_t push_block,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output spbw_pkg::block_t      pop_block
);

	spbw_pkg::block_t              mem_q [spbw_pkg::QUEUE_DEPTH];
	logic [spbw_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [spbw_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [spbw_pkg::QCNT_W-1:0]   count_q;
	logic                          push;
	logic                          pop;

	assign push_ready = count_q != spbw_pkg::QCNT_W'(spbw_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_block  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_block;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/spbw_back.sv */
// Back of the pixel block writer: walks each queued block row by row, one write
// per cycle while writes is ready. Uses spbw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module spbw_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire spbw_pkg::cfg_t   cfg,
	input  wire logic             pop_valid,
	output logic                  pop_ready,
	input  wire spbw_pkg::block_t pop_block,
	spbw_out_if.source            writes
);

	logic                        busy_q;
	logic [31:0]                 addr_q;
	logic [31:0]                 row_addr_q;
	logic [23:0]                 data_q;
	logic [spbw_pkg::CCNT_W-1:0] col_q;
	logic [spbw_pkg::NCNT_W-1:0] n_q;
	logic                        is_last;
	logic                        step;
	logic [31:0]                 next_row_addr;
	logic [31:0]                 load_addr;

	assign is_last       = n_q == spbw_pkg::NCNT_W'(spbw_pkg::LAST_N);
	assign pop_ready     = !busy_q || (writes.ready && is_last);
	assign step          = busy_q && writes.ready && !is_last;
	assign next_row_addr = row_addr_q + 32'(cfg.line_pitch);
	assign load_addr     = cfg.frame_base + pop_block.offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (pop_ready) begin
			busy_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready) begin
			// Load the next block at its first write.
			addr_q     <= load_addr;
			row_addr_q <= load_addr;
			data_q     <= pop_block.color;
			col_q      <= '0;
			n_q        <= '0;
		end else if (step) begin
			n_q <= n_q + 1'b1;
			if (col_q == spbw_pkg::CCNT_W'(spbw_pkg::LAST_COL)) begin
				col_q      <= '0;
				row_addr_q <= next_row_addr;
				addr_q     <= next_row_addr;
			end else begin
				col_q  <= col_q + 1'b1;
				addr_q <= addr_q + 32'd4;
			end
		end
	end

	assign writes.valid         = busy_q;
	assign writes.write_address = addr_q;
	assign writes.write_data    = data_q;
	assign writes.last_write    = is_last;

	`ASSERT_PROP(a_block_continues, clk, arst_n, step |=> busy_q, "block ended before last write")
	`ASSERT_NEVER(a_count_range, clk, arst_n,
		busy_q && (n_q > spbw_pkg::NCNT_W'(spbw_pkg::LAST_N)), "write count past block size")
	`ASSERT_NEVER(a_col_range, clk, arst_n,
		busy_q && (col_q > spbw_pkg::CCNT_W'(spbw_pkg::LAST_COL)), "column past block width")
	`ASSERT_PROP(a_addr_step, clk, arst_n,
		(step && (col_q != spbw_pkg::CCNT_W'(spbw_pkg::LAST_COL))) |=>
		(addr_q == $past(addr_q) + 32'd4), "column address step wrong")

endmodule

`default_nettype wire

/* rtl/core/scaled_pixel_block_writer.sv */
// Top level of the scaled pixel block writer: configuration registers and the
// front, queue and back parts. Uses spbw_pkg, spbw_in_if and spbw_out_if.
//
//  channel   | role   | payload                                  | beat
//  ----------+--------+------------------------------------------+-----------------
//  pixels    | sink   | src_x, src_y, src_color                  | one source pixel
//  writes    | source | write_address, write_data, last_write    | one 32-bit write
//  cfg_*     | write  | cfg_index, cfg_data                      | one register
//
// Each in-range pixel becomes SCALE_X*SCALE_Y writes (at most MAX_WRITES; 16 in
// this geometry), one per cycle while writes is ready; the back's block walker
// sets the rate. Out-of-range pixels transfer at one per cycle when the front is
// not stalled and give no writes. Writes pass front s1, s2, the queue and back.
// Reset clears control state and sets frame_base to 0, line_pitch to 4096.
// A stalled writes channel holds the current write; the four-entry queue keeps
// the front taking pixels until it fills.
`default_nettype none

module scaled_pixel_block_writer (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	spbw_in_if.sink                                  pixels,
	spbw_out_if.source                               writes,
	input  wire logic                                cfg_wr_en,
	input  wire logic [spbw_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [spbw_pkg::CFG_DATA_W-1:0]     cfg_data
);

	spbw_pkg::cfg_t   cfg_q;
	logic             push_valid;
	logic             push_ready;
	spbw_pkg::block_t push_block;
	logic             pop_valid;
	logic             pop_ready;
	spbw_pkg::block_t pop_block;

	// Register file; writes to unknown indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_base <= 32'd0;
			cfg_q.line_pitch <= 16'd4096;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				spbw_pkg::REG_FRAME_BASE: cfg_q.frame_base <= cfg_data[31:0];
				spbw_pkg::REG_LINE_PITCH: cfg_q.line_pitch <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Front: classify the pixel and compute the block's offset.
	spbw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixels     (pixels),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_block (push_block)
	);

	// Queue: decouple pixel intake from write issue.
	spbw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_block (push_block),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_block  (pop_block)
	);

	// Back: walk each block and transfer its writes.
	spbw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_block (pop_block),
		.writes    (writes)
	);

endmodule

`default_nettype wire

/* tb/scaled_pixel_block_writer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of scaled_pixel_block_writer: drives source pixels, predicts
// every framebuffer write and compares each one. Needs spbw_pkg, spbw_in_if, spbw_out_if.

module scaled_pixel_block_writer_tb;

	localparam int CLK_HALF        = 2;
	localparam int RESET_CYCLES    = 4;
	localparam int WATCHDOG_LIMIT  = 4000;
	// Settling time after the last predicted write, so that dropped pixels
	// comfortably leave the pipeline.
	localparam int SETTLE_CYCLES   = 12;
	localparam int MAX_REPORTS     = 10;
	localparam int LONG_HOLD       = 300;
	localparam int ITEMS_PER_PHASE = 95;
	localparam int STALL_ITEMS     = 24;
	localparam int OUT_OF_RANGE_PCT = 12;
	localparam logic [15:0] RESET_PITCH = 16'd4096;

	// Indexes past the register file; writes to them must change nothing.
	localparam logic [spbw_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [spbw_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [31:0] address;
		logic [23:0] data;
		logic        last;
	} fb_write_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_wr_en;
	logic [spbw_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [spbw_pkg::CFG_DATA_W-1:0]  cfg_data;

	spbw_in_if  pix_if();
	spbw_out_if wr_if();

	scaled_pixel_block_writer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pix_if),
		.writes    (wr_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the register file, updated as each write lands.
	logic [31:0] model_base  = 32'd0;
	logic [15:0] model_pitch = RESET_PITCH;

	// Writes predicted but not yet seen on the write channel, oldest first.
	fb_write_t pending_writes[$];

	int unsigned error_count        = 0;
	int unsigned idle_cycles        = 0;
	int unsigned sender_idle_pct    = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned hold_off_cycles    = 0;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Count a failure; print only the first few so a broken block cannot flood the log.
	function automatic void note_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%t: %s", $realtime, msg);
	endfunction

	// Widen one 5-bit channel to 8 bits by copying its top bits into the low end.
	function automatic logic [7:0] widen_channel(input logic [4:0] c);
		return {c, c[4:2]};
	endfunction

	// RGB555 to RGB888: bits 0-4 land in byte 2, bits 10-14 in byte 0; bit 15 is dropped.
	function automatic logic [23:0] rgb888_of(input logic [15:0] color);
		return {widen_channel(color[4:0]), widen_channel(color[9:5]),
			widen_channel(color[14:10])};
	endfunction

	// Queue the writes one source pixel turns into: a row-major walk over its scaled
	// block, clipped at the destination edge and cut off after MAX_WRITES.
	function automatic void expand_pixel_block(input logic [7:0] x, input logic [7:0] y,
			input logic [15:0] color);
		int unsigned scale_x, scale_y, row, col, row_end, col_end, count;
		fb_write_t w;
		scale_x = spbw_pkg::DST_WIDTH / spbw_pkg::SRC_WIDTH;
		scale_y = spbw_pkg::DST_HEIGHT / spbw_pkg::SRC_HEIGHT;
		if (x >= spbw_pkg::SRC_WIDTH || y >= spbw_pkg::SRC_HEIGHT)
			return;
		row_end = (y + 1) * scale_y;
		if (row_end > spbw_pkg::DST_HEIGHT)
			row_end = spbw_pkg::DST_HEIGHT;
		col_end = (x + 1) * scale_x;
		if (col_end > spbw_pkg::DST_WIDTH)
			col_end = spbw_pkg::DST_WIDTH;
		count = 0;
		for (row = y * scale_y; row < row_end && count < spbw_pkg::MAX_WRITES; row++) begin
			for (col = x * scale_x; col < col_end && count < spbw_pkg::MAX_WRITES;
					col++) begin
				// 32-bit wraparound is intended here
				w.address = 32'(model_base + 32'(model_pitch) * row + 4 * col);
				w.data    = rgb888_of(color);
				w.last    = 1'b0;
				pending_writes.push_back(w);
				count++;
			end
		end
		if (count != 0) begin
			w = pending_writes.pop_back();
			w.last = 1'b1;
			pending_writes.push_back(w);
		end
	endfunction

	// Predict on every pixel transfer. Both sides are sampled at the edge, before
	// any nonblocking update of this step lands.
	always @(posedge clk) begin
		if (arst_n && pix_if.valid && pix_if.ready)
			expand_pixel_block(pix_if.src_x, pix_if.src_y, pix_if.src_color);
	end

	// Compare every write transfer against the oldest prediction.
	always @(posedge clk) begin : check_writes
		fb_write_t want;
		if (arst_n && wr_if.valid && wr_if.ready) begin
			if (pending_writes.size() == 0) begin
				note_error($sformatf("write with nothing predicted: addr %h data %h last %b",
					wr_if.write_address, wr_if.write_data, wr_if.last_write));
			end else begin
				want = pending_writes.pop_front();
				if (wr_if.write_address !== want.address)
					note_error($sformatf("write_address: expected %h, got %h",
						want.address, wr_if.write_address));
				if (wr_if.write_data !== want.data)
					note_error($sformatf("write_data at %h: expected %h, got %h",
						want.address, want.data, wr_if.write_data));
				if (wr_if.last_write !== want.last)
					note_error($sformatf("last_write at %h: expected %b, got %b",
						want.address, want.last, wr_if.last_write));
			end
		end
	end

	// Hang detector: any transfer on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (pix_if.valid && pix_if.ready) || (wr_if.valid && wr_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Write channel sink. Stall at the current rate; on request, hold ready low for a
	// long stretch counted here, so the queue fills and the pixel side backs up.
	initial begin : drive_write_ready
		int unsigned held;
		wr_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				wr_if.ready <= 1'b0;
			end else if (hold_off_cycles != 0) begin
				wr_if.ready <= 1'b0;
				for (held = 0; held < hold_off_cycles; held++)
					@(posedge clk);
				hold_off_cycles = 0;
			end else begin
				wr_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// Offer one pixel and hold it until it transfers. Valid is left high on return so
	// back-to-back pixels never drop it; only an idle gap or wait_idle lowers it.
	task automatic send_pixel(input logic [7:0] x, input logic [7:0] y,
			input logic [15:0] color);
		if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			pix_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		pix_if.valid     <= 1'b1;
		pix_if.src_x     <= x;
		pix_if.src_y     <= y;
		pix_if.src_color <= color;
		do @(posedge clk); while (!pix_if.ready);
	endtask

	// Mostly in-range pixels with random color; the rest fall off the source.
	task automatic send_random_pixel();
		logic [7:0] x, y;
		if ($urandom_range(99) < OUT_OF_RANGE_PCT) begin
			x = 8'($urandom_range(255));
			y = 8'($urandom_range(255));
			if (x < spbw_pkg::SRC_WIDTH && y < spbw_pkg::SRC_HEIGHT) begin
				if ($urandom_range(1))
					x = 8'($urandom_range(255, spbw_pkg::SRC_WIDTH));
				else
					y = 8'($urandom_range(255, spbw_pkg::SRC_HEIGHT));
			end
		end else begin
			x = 8'($urandom_range(spbw_pkg::SRC_WIDTH - 1));
			y = 8'($urandom_range(spbw_pkg::SRC_HEIGHT - 1));
		end
		send_pixel(x, y, 16'($urandom));
	endtask

	// Drop valid, let every predicted write drain, then give dropped pixels time to
	// clear the pipeline so the block is truly idle.
	task automatic wait_idle();
		pix_if.valid <= 1'b0;
		do @(posedge clk); while (pending_writes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the enable drops on the following cycle so that
	// consecutive writes never reassign it within one step.
	task automatic write_reg(input logic [spbw_pkg::CFG_INDEX_W-1:0] index,
			input logic [spbw_pkg::CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (index)
			spbw_pkg::REG_FRAME_BASE: model_base = value;
			spbw_pkg::REG_LINE_PITCH: model_pitch = value[15:0];
			default: ;
		endcase
	endtask

	// Base and pitch, with junk in the pitch's unused upper half.
	task automatic apply_setting(input logic [31:0] base, input logic [15:0] pitch);
		wait_idle();
		write_reg(spbw_pkg::REG_FRAME_BASE, base);
		write_reg(spbw_pkg::REG_LINE_PITCH, {16'($urandom), pitch});
	endtask

	// Reset values of the registers, before any write.
	task automatic test_reset_values();
		send_pixel(8'd0, 8'd0, 16'h7FFF);
		send_pixel(8'd17, 8'd93, 16'h1234);
	endtask

	// Source corners, both rejection edges, the largest coordinates and one-hot colors.
	task automatic test_corner_pixels();
		send_pixel(8'd0, 8'd0, 16'h0000);
		send_pixel(8'd239, 8'd159, 16'hFFFF);
		send_pixel(8'd0, 8'd159, 16'h001F);
		send_pixel(8'd239, 8'd0, 16'h03E0);
		send_pixel(8'd240, 8'd0, 16'h7C00);
		send_pixel(8'd0, 8'd160, 16'h8000);
		send_pixel(8'd255, 8'd255, 16'hFFFF);
		send_pixel(8'd238, 8'd158, 16'h8000);
		send_pixel(8'd120, 8'd80, 16'h5555);
		send_pixel(8'd1, 8'd1, 16'hAAAA);
		send_pixel(8'd240, 8'd160, 16'h0001);
		send_pixel(8'd239, 8'd1, 16'h4210);
	endtask

	// Extreme register values, including address wraparound and a zero pitch, then
	// writes to unused indexes, which must leave the registers alone.
	task automatic test_register_settings();
		apply_setting(32'hFFFF_FFFF, 16'hFFFF);
		send_pixel(8'd239, 8'd159, 16'h7FFF);
		send_pixel(8'd3, 8'd2, 16'h0421);
		apply_setting(32'h0000_0000, 16'h0000);
		send_pixel(8'd100, 8'd150, 16'h3DEF);
		send_pixel(8'd239, 8'd159, 16'h0000);
		apply_setting(32'h8000_0000, 16'h0001);
		send_pixel(8'd0, 8'd159, 16'hFFFF);
		send_pixel(8'd239, 8'd0, 16'h2A2A);
		wait_idle();
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
		send_pixel(8'd77, 8'd66, 16'h6B5A);
		send_pixel(8'd5, 8'd159, 16'h1F1F);
	endtask

	// Random pixels under each idling mix, with a fresh register setting per phase.
	task automatic test_random_traffic();
		int unsigned phase;
		int unsigned send_gap[4]  = '{0, 82, 0, 19};
		int unsigned recv_stall[4] = '{0, 0, 82, 19};
		for (phase = 0; phase < 4; phase++) begin
			if (phase == 3)
				apply_setting(32'hFFFF_F000, 16'hFFFF);
			else
				apply_setting($urandom, 16'($urandom));
			sender_idle_pct    = send_gap[phase];
			receiver_stall_pct = recv_stall[phase];
			repeat (ITEMS_PER_PHASE) send_random_pixel();
		end
		wait_idle();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
	endtask

	// Hold the write side off while pixels keep coming, so the queue fills and
	// the pixel channel has to stall.
	task automatic test_long_stall();
		apply_setting($urandom, 16'd4096);
		hold_off_cycles = LONG_HOLD;
		repeat (STALL_ITEMS) send_random_pixel();
		wait_idle();
	endtask

	initial begin
		pix_if.valid     = 1'b0;
		pix_if.src_x     = 8'd0;
		pix_if.src_y     = 8'd0;
		pix_if.src_color = 16'd0;
		cfg_wr_en        = 1'b0;
		cfg_index        = spbw_pkg::REG_FRAME_BASE;
		cfg_data         = '0;
		arst_n           = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_corner_pixels();
		test_register_settings();
		test_random_traffic();
		test_long_stall();
		wait_idle();

		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
